// ===== design/sobc_pkg.sv =====
// Shared types and constants for the segment obstacle checker.
// Used by the top level and the orientation unit; depends on nothing.
package sobc_pkg;

  localparam int MAX_OBSTACLES_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;

  // Width of the per-obstacle step counter and its last step.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_MUL_LAST = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ORI_LAST = 4'd8;
  localparam logic [STEP_W-1:0] STEP_LAST     = 4'd9;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Sign of a cross product: collinear, positive, negative.
  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_POS = 2'd1,
    ORI_NEG = 2'd2
  } ori_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CALC,
    ST_RESPOND
  } state_t;

  // Control of the shared orientation unit for one cycle.
  typedef struct packed {
    logic [1:0] pick;        // which of the four orientations
    logic       half;        // 0: first product, 1: second product
    logic       mul_en;      // load the product register
    logic       take_first;  // keep the product as the first term
  } ori_ctl_t;

endpackage

// ===== design/segment_obstacle_check.sv =====
// Segment obstacle checker: top level. Holds the obstacle table and the query sequencer.
// Depends on sobc_pkg, sobc_ram and sobc_orient.
//
// The block keeps a table of up to MAX_OBSTACLES obstacle line segments in
// integer pixel coordinates and answers one item per transfer: clear the table,
// append one obstacle, or query a path segment against every stored obstacle.
// A query reports blocked when any obstacle intersects the path, where
// collinear overlap and touching endpoints count as intersections; the test is
// the exact three-way sign of each cross product. An append to a full table is
// dropped and reports status 1. Every item returns one result transfer carrying
// the number of obstacles held afterwards. A clear, an append, an unused action
// code or a query of an empty table goes from the input transfer straight to
// the respond state. A query walks the stored obstacles in order and stops at
// the first hit, or after the last obstacle when the path is clear. Each
// obstacle costs one table read and then a pass through the shared orientation
// unit: its single multiplier forms the cross-product terms one per cycle,
// a further step takes the last orientation, and a decision step follows.
// The block takes no new item until the current one has produced its result,
// but it does accept the next item while that result still waits at the output.
// No clearing pass is needed after reset; the table is tracked by its fill count.
module segment_obstacle_check #(
  parameter int MAX_OBSTACLES = sobc_pkg::MAX_OBSTACLES_DEF,
  parameter int COORD_BITS    = sobc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic signed [COORD_BITS-1:0] from_x,
  input  logic signed [COORD_BITS-1:0] from_y,
  input  logic signed [COORD_BITS-1:0] to_x,
  input  logic signed [COORD_BITS-1:0] to_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         status,
  output logic                         blocked,
  output logic [8:0]                   stored_count
);

  localparam int CW = $clog2(MAX_OBSTACLES + 1);
  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int EW = 4 * COORD_BITS;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_OBSTACLES);

  sobc_pkg::state_t state, state_next;

  logic [CW-1:0]                count;
  logic [CW-1:0]                idx;
  logic [sobc_pkg::STEP_W-1:0]  step;
  logic signed [COORD_BITS-1:0] s_ax, s_ay, s_bx, s_by;
  logic                         res_status;
  logic                         res_blocked;
  sobc_pkg::ori_t               orient_sign [4];

  logic                         accept;
  logic                         table_full;
  logic                         idx_last;
  logic                         hit;
  logic                         out_free;
  logic                         ram_we;
  logic                         ram_re;
  logic [EW-1:0]                ram_rdata;
  logic signed [COORD_BITS-1:0] t_ax, t_ay, t_bx, t_by;
  sobc_pkg::ori_ctl_t           ori_ctl;
  sobc_pkg::ori_t               ori_now;
  sobc_pkg::action_t            act;

  assign act        = sobc_pkg::action_t'(action);
  assign accept     = in_valid && !in_stall;
  assign table_full = (count >= COUNT_MAX);
  assign idx_last   = (CW'(idx + CW'(1)) == count);
  assign out_free   = !out_valid || !out_stall;

  // Obstacle table. Only entries below the fill count are ever read.
  sobc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({from_x, from_y, to_x, to_y}),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign t_ax = ram_rdata[4*COORD_BITS-1:3*COORD_BITS];
  assign t_ay = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign t_bx = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign t_by = ram_rdata[COORD_BITS-1:0];

  sobc_orient #(
    .COORD_BITS (COORD_BITS)
  ) u_orient (
    .clk  (clk),
    .ctl  (ori_ctl),
    .s_ax (s_ax),
    .s_ay (s_ay),
    .s_bx (s_bx),
    .s_by (s_by),
    .t_ax (t_ax),
    .t_ay (t_ay),
    .t_bx (t_bx),
    .t_by (t_by),
    .ori  (ori_now)
  );

  // True when point q lies inside the bounding box of p and r.
  function automatic logic in_bbox(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] qx,
    input logic signed [COORD_BITS-1:0] qy,
    input logic signed [COORD_BITS-1:0] rx,
    input logic signed [COORD_BITS-1:0] ry
  );
    logic x_ok;
    logic y_ok;
    x_ok = (qx <= px || qx <= rx) && (qx >= px || qx >= rx);
    y_ok = (qy <= py || qy <= ry) && (qy >= py || qy >= ry);
    return x_ok && y_ok;
  endfunction

  // Decision for the current obstacle once all four orientations are held.
  always_comb begin
    hit = (orient_sign[0] != orient_sign[1]) && (orient_sign[2] != orient_sign[3]);
    if (orient_sign[0] == sobc_pkg::ORI_COL && in_bbox(s_ax, s_ay, t_ax, t_ay, s_bx, s_by)) begin
      hit = 1'b1;
    end
    if (orient_sign[1] == sobc_pkg::ORI_COL && in_bbox(s_ax, s_ay, t_bx, t_by, s_bx, s_by)) begin
      hit = 1'b1;
    end
    if (orient_sign[2] == sobc_pkg::ORI_COL && in_bbox(t_ax, t_ay, s_ax, s_ay, t_bx, t_by)) begin
      hit = 1'b1;
    end
    if (orient_sign[3] == sobc_pkg::ORI_COL && in_bbox(t_ax, t_ay, s_bx, s_by, t_bx, t_by)) begin
      hit = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sobc_pkg::ST_IDLE: begin
        if (accept) begin
          if (act == sobc_pkg::ACT_QUERY && count != '0) begin
            state_next = sobc_pkg::ST_FETCH;
          end else begin
            state_next = sobc_pkg::ST_RESPOND;
          end
        end
      end
      sobc_pkg::ST_FETCH: begin
        state_next = sobc_pkg::ST_CALC;
      end
      sobc_pkg::ST_CALC: begin
        if (step == sobc_pkg::STEP_LAST) begin
          if (hit || idx_last) begin
            state_next = sobc_pkg::ST_RESPOND;
          end else begin
            state_next = sobc_pkg::ST_FETCH;
          end
        end
      end
      sobc_pkg::ST_RESPOND: begin
        if (out_free) begin
          state_next = sobc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sobc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer. Products are formed in steps 0 to 7;
  // an odd step keeps the first term of an orientation, an even step from 2
  // to 8 sees the finished orientation at the unit's output.
  always_comb begin
    in_stall           = (state != sobc_pkg::ST_IDLE);
    ram_we             = accept && act == sobc_pkg::ACT_APPEND && !table_full;
    ram_re             = (state == sobc_pkg::ST_FETCH);
    ori_ctl.pick       = step[2:1];
    ori_ctl.half       = step[0];
    ori_ctl.mul_en     = (state == sobc_pkg::ST_CALC) && step <= sobc_pkg::STEP_MUL_LAST;
    ori_ctl.take_first = (state == sobc_pkg::ST_CALC) && step[0]
                         && step <= sobc_pkg::STEP_MUL_LAST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sobc_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        unique case (act)
          sobc_pkg::ACT_CLEAR:  count <= '0;
          sobc_pkg::ACT_APPEND: begin
            if (!table_full) begin
              count <= CW'(count + CW'(1));
            end
          end
          sobc_pkg::ACT_QUERY,
          sobc_pkg::ACT_NONE:   count <= count;
          default:              count <= count;
        endcase
      end

      if (state == sobc_pkg::ST_RESPOND && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_ax        <= from_x;
      s_ay        <= from_y;
      s_bx        <= to_x;
      s_by        <= to_y;
      idx         <= '0;
      res_status  <= (act == sobc_pkg::ACT_APPEND) && table_full;
      res_blocked <= 1'b0;
    end

    if (state == sobc_pkg::ST_FETCH) begin
      step <= '0;
    end

    if (state == sobc_pkg::ST_CALC) begin
      step <= sobc_pkg::STEP_W'(step + 1'b1);
      if (!step[0] && step != '0 && step <= sobc_pkg::STEP_ORI_LAST) begin
        orient_sign[2'(step[3:1] - 3'd1)] <= ori_now;
      end
      if (step == sobc_pkg::STEP_LAST) begin
        if (hit) begin
          res_blocked <= 1'b1;
        end else begin
          idx <= CW'(idx + CW'(1));
        end
      end
    end

    if (state == sobc_pkg::ST_RESPOND && out_free) begin
      status       <= res_status;
      blocked      <= res_blocked;
      stored_count <= 9'(count);
    end
  end

  // The fill count never passes the table capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("obstacle count exceeds table capacity");

  // A table read only ever touches an entry that was written.
  a_read_written: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> idx < count)
    else $error("table read beyond fill count");

  // An accepted item holds off the next one in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input accepted while an item is in progress");

  // A query walk never runs over an empty table.
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == sobc_pkg::ST_CALC || state == sobc_pkg::ST_FETCH) |-> count != '0)
    else $error("query walk with an empty table");

endmodule

// ===== design/sobc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sobc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sobc_orient.sv =====
// Shared orientation unit: one multiplier and three subtractors, used for one
// product per cycle while mul_en is set. Depends on sobc_pkg.
module sobc_orient #(
  parameter int COORD_BITS = sobc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  sobc_pkg::ori_ctl_t            ctl,
  input  logic signed [COORD_BITS-1:0]  s_ax,
  input  logic signed [COORD_BITS-1:0]  s_ay,
  input  logic signed [COORD_BITS-1:0]  s_bx,
  input  logic signed [COORD_BITS-1:0]  s_by,
  input  logic signed [COORD_BITS-1:0]  t_ax,
  input  logic signed [COORD_BITS-1:0]  t_ay,
  input  logic signed [COORD_BITS-1:0]  t_bx,
  input  logic signed [COORD_BITS-1:0]  t_by,
  output sobc_pkg::ori_t                ori
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int VW = PW + 1;

  logic signed [COORD_BITS-1:0] px, py, qx, qy, rx, ry;
  logic signed [DW-1:0]         d1, d2;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         first;
  logic signed [VW-1:0]         diff;

  // The first two orientations take the query as the base line, the last
  // two take the obstacle.
  always_comb begin
    case (ctl.pick)
      2'd0: begin px = s_ax; py = s_ay; qx = s_bx; qy = s_by; rx = t_ax; ry = t_ay; end
      2'd1: begin px = s_ax; py = s_ay; qx = s_bx; qy = s_by; rx = t_bx; ry = t_by; end
      2'd2: begin px = t_ax; py = t_ay; qx = t_bx; qy = t_by; rx = s_ax; ry = s_ay; end
      2'd3: begin px = t_ax; py = t_ay; qx = t_bx; qy = t_by; rx = s_bx; ry = s_by; end
      default: begin px = s_ax; py = s_ay; qx = s_bx; qy = s_by; rx = t_ax; ry = t_ay; end
    endcase
  end

  always_comb begin
    if (ctl.half) begin
      d1 = DW'(qx) - DW'(px);
      d2 = DW'(ry) - DW'(qy);
    end else begin
      d1 = DW'(qy) - DW'(py);
      d2 = DW'(rx) - DW'(qx);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= d1 * d2;
    end
    if (ctl.take_first) begin
      first <= prod;
    end
  end

  assign diff = VW'(first) - VW'(prod);

  always_comb begin
    if (diff == '0) begin
      ori = sobc_pkg::ORI_COL;
    end else if (diff[VW-1]) begin
      ori = sobc_pkg::ORI_NEG;
    end else begin
      ori = sobc_pkg::ORI_POS;
    end
  end

endmodule
